// File: src/iss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Shared constants, operation codes and types of the sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FUNC_W    = 4;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned STATUS_W  = 2;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND   = 4'd0,
    FN_INSERT   = 4'd1,
    FN_REMOVE   = 4'd2,
    FN_POP      = 4'd3,
    FN_RM_FIRST = 4'd4,
    FN_RM_LAST  = 4'd5,
    FN_RM_ALL   = 4'd6,
    FN_REVERSE  = 4'd7,
    FN_MIN      = 4'd8,
    FN_MAX      = 4'd9,
    FN_CLEAR    = 4'd10
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Per-cycle command that every cell receives from the controller.
  typedef enum logic [2:0] {
    CC_HOLD,
    CC_SHIFT_UP,
    CC_SHIFT_DOWN,
    CC_ROTATE,
    CC_COMPACT
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

endpackage : iss_pkg
`default_nettype wire

// File: src/iss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence store cell
// Holds one entry and takes part in the chain moves.
// ----------------------------------------------------------------------------
module iss_cell
  import iss_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic                     sel,
  input  wire logic                     ins_here,
  input  wire logic signed [DATA_W-1:0] from_lo,
  input  wire logic signed [DATA_W-1:0] from_hi,
  input  wire logic signed [DATA_W-1:0] comp_in,
  output logic signed [DATA_W-1:0]      data
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (sel) begin
      unique case (ctl.op)
        CC_SHIFT_UP:   data_nxt = ins_here ? ctl.value : from_lo;
        CC_SHIFT_DOWN: data_nxt = from_hi;
        CC_ROTATE:     data_nxt = from_hi;
        CC_COMPACT:    data_nxt = comp_in;
        default:       data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule : iss_cell
`default_nettype wire

// File: src/iss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence store controller
// Sequences each operation over the chain one step per cycle.
// ----------------------------------------------------------------------------
module iss_ctrl
  import iss_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned POS_W = $clog2(DEPTH)
)
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic signed [INDEX_W-1:0] in_index,
  input  wire logic signed [DATA_W-1:0] head_data,
  output cell_ctl_t                     ctl,
  output logic [POS_W-1:0]              lo_pos,
  output logic [CNT_W-1:0]              hi_pos,
  output logic                          busy,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_result,
  output logic [STATUS_W-1:0]           out_status,
  output logic [6:0]                    out_count
);

  localparam int unsigned IW = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 2;

  state_t                   state_r, state_nxt;
  func_t                    func_r, func_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]         len_r, len_nxt;
  logic [CNT_W-1:0]         step_r, step_nxt;
  logic [CNT_W-1:0]         keep_r, keep_nxt;
  logic [POS_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  status_t                  st_r, st_nxt;
  logic                     found_r, found_nxt;
  logic                     ov_r, ov_nxt;
  cell_op_t                 op_c;
  logic signed [IW-1:0]     idx_s, n_s, p_s;
  logic                     match;

  assign match = (head_data == val_r);

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    val_nxt   = val_r;
    len_nxt   = len_r;
    step_nxt  = step_r;
    keep_nxt  = keep_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    found_nxt = found_r;
    ov_nxt    = 1'b0;
    op_c      = CC_HOLD;
    idx_s     = IW'(in_index);
    n_s       = IW'({1'b0, len_r});
    p_s       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && !ov_r) begin
          func_nxt  = func_t'(in_func);
          val_nxt   = in_value;
          res_nxt   = '0;
          st_nxt    = ST_OK;
          found_nxt = 1'b0;
          step_nxt  = '0;
          keep_nxt  = '0;
          lo_nxt    = '0;
          hi_nxt    = len_r;
          state_nxt = S_DONE;
          unique case (in_func)
            FN_APPEND, FN_INSERT: begin
              if (len_r == CNT_W'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                p_s = n_s;
                if (in_func == FN_INSERT) begin
                  p_s = (idx_s < 0) ? idx_s + n_s + IW'(1) : idx_s;
                  if (p_s < 0) p_s = '0;
                  if (p_s > n_s) p_s = n_s;
                end
                lo_nxt    = POS_W'(p_s[CNT_W-1:0]);
                hi_nxt    = len_r;
                state_nxt = S_RUN;
              end
            end
            FN_REMOVE, FN_POP: begin
              if (len_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                p_s = (idx_s < 0) ? idx_s + n_s : idx_s;
                if (p_s < 0) p_s = '0;
                if (p_s > n_s - IW'(1)) p_s = n_s - IW'(1);
                // Pop rotates its entry to the head and drops it there.
                lo_nxt    = (in_func == FN_POP) ? '0 : POS_W'(p_s[CNT_W-1:0]);
                step_nxt  = CNT_W'(p_s[CNT_W-1:0]);
                keep_nxt  = CNT_W'(p_s[CNT_W-1:0]);
                state_nxt = S_RUN;
              end
            end
            FN_RM_FIRST, FN_RM_LAST, FN_RM_ALL, FN_MIN, FN_MAX: begin
              if (len_r == '0) begin
                st_nxt = ST_EMPTY;
                if (in_func == FN_MIN) res_nxt = INT_MAX;
                if (in_func == FN_MAX) res_nxt = INT_MIN;
              end else begin
                res_nxt   = (in_func == FN_MIN) ? INT_MAX :
                            (in_func == FN_MAX) ? INT_MIN : '0;
                state_nxt = S_RUN;
              end
            end
            FN_REVERSE: begin
              if (len_r > CNT_W'(1)) state_nxt = S_RUN;
            end
            FN_CLEAR: len_nxt = '0;
            default: ;
          endcase
        end
      end
      S_RUN: begin
        // Each search walk rotates the live entries once; cell 0 is inspected.
        unique case (func_r)
          FN_APPEND, FN_INSERT: begin
            op_c      = CC_SHIFT_UP;
            len_nxt   = len_r + CNT_W'(1);
            state_nxt = S_DONE;
          end
          FN_REMOVE, FN_POP: begin
            if (func_r == FN_POP) begin
              if (found_r) begin
                if (step_r == '0) begin
                  state_nxt = S_DONE;
                end else begin
                  op_c     = CC_ROTATE;
                  step_nxt = step_r - CNT_W'(1);
                end
              end else if (step_r == '0) begin
                res_nxt   = head_data;
                op_c      = CC_SHIFT_DOWN;
                len_nxt   = len_r - CNT_W'(1);
                step_nxt  = len_r - CNT_W'(1) - keep_r;
                found_nxt = 1'b1;
              end else begin
                op_c     = CC_ROTATE;
                step_nxt = step_r - CNT_W'(1);
              end
            end else begin
              op_c      = CC_SHIFT_DOWN;
              len_nxt   = len_r - CNT_W'(1);
              state_nxt = S_DONE;
            end
          end
          FN_RM_FIRST, FN_RM_LAST, FN_RM_ALL, FN_MIN, FN_MAX: begin
            op_c     = CC_COMPACT;
            step_nxt = step_r + CNT_W'(1);
            keep_nxt = keep_r + CNT_W'(1);
            if (func_r == FN_MIN && head_data < res_r) res_nxt = head_data;
            if (func_r == FN_MAX && head_data > res_r) res_nxt = head_data;
            if (func_r == FN_RM_FIRST && match && !found_r) begin
              found_nxt = 1'b1;
              keep_nxt  = keep_r;
              op_c      = CC_SHIFT_DOWN;
              len_nxt   = len_r - CNT_W'(1);
            end
            if (func_r == FN_RM_ALL && match) begin
              found_nxt = 1'b1;
              keep_nxt  = keep_r;
              op_c      = CC_SHIFT_DOWN;
              len_nxt   = len_r - CNT_W'(1);
            end
            if (func_r == FN_RM_LAST && match) begin
              found_nxt = 1'b1;
              hi_nxt    = step_r;
            end
            if (keep_r + CNT_W'(1) == len_r) begin
              len_nxt   = keep_nxt;
              state_nxt = S_DONE;
              if (func_r == FN_RM_LAST) begin
                len_nxt = len_r;
                if (found_nxt) begin
                  lo_nxt    = POS_W'(hi_nxt);
                  step_nxt  = '0;
                  state_nxt = S_RUN;
                  func_nxt  = FN_REMOVE;
                end
              end
              if ((func_r == FN_RM_FIRST || func_r == FN_RM_LAST ||
                   func_r == FN_RM_ALL) && !found_nxt) begin
                st_nxt = ST_NOTFOUND;
              end
            end
          end
          FN_REVERSE: begin
            // Rotating a window that shrinks by one each cycle reverses it.
            op_c   = CC_ROTATE;
            hi_nxt = hi_r - CNT_W'(1);
            if (hi_r == CNT_W'(2)) state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ov_r    <= ov_nxt;
    end
    func_r  <= func_nxt;
    val_r   <= val_nxt;
    step_r  <= step_nxt;
    keep_r  <= keep_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    res_r   <= res_nxt;
    st_r    <= st_nxt;
    found_r <= found_nxt;
  end

  assign ctl.op    = op_c;
  assign ctl.value = val_r;
  assign lo_pos    = lo_r;
  assign hi_pos    = (func_r == FN_REVERSE) ? hi_r : len_r;
  assign busy      = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_result = res_r;
  assign out_status = st_r;
  assign out_count  = 7'(len_r);

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNT_W'(DEPTH)) else $error("length beyond depth");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("result strobe longer than a cycle");
  a_full_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r == ST_FULL) |-> len_r == CNT_W'(DEPTH))
    else $error("full status with room left");

endmodule : iss_ctrl
`default_nettype wire

// File: src/indexed_sequence_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed sequence store
// Ordered store of signed words kept in a chain of cells.
//
//   Channel  Direction  Handshake             Ports
//   in       input      start & !busy         in_func, in_value, in_index
//   out      output     out_valid (strobe)    out_result, out_status, out_count
//
// Append, insert and remove shift the chain; pop rotates its entry to the
// head, drops it there and rotates the rest back. Remove first/last/all,
// min and max walk the live entries and reverse rotates a shrinking window;
// rejected, empty-store, clear and unused items finish without a walk.
// The result strobe lasts one cycle and busy stays high until it has gone;
// the receiver cannot stall. Synchronous reset clears only state, length, strobe.
// ----------------------------------------------------------------------------
module indexed_sequence_store
  import iss_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
)
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [FUNC_W-1:0]         in_func,
  input  wire logic signed [DATA_W-1:0]  in_value,
  input  wire logic signed [INDEX_W-1:0] in_index,
  output logic                           out_valid,
  output logic signed [DATA_W-1:0]       out_result,
  output logic [STATUS_W-1:0]            out_status,
  output logic [6:0]                     out_count
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = $clog2(DEPTH);

  cell_ctl_t                ctl;
  logic [POS_W-1:0]         lo_pos;
  logic [CNT_W-1:0]         hi_pos;
  logic signed [DATA_W-1:0] data [DEPTH];

  iss_ctrl #(.DEPTH(DEPTH), .CNT_W(CNT_W), .POS_W(POS_W)) u_ctrl (
    .clk, .rst_n, .start, .in_func, .in_value, .in_index,
    .head_data(data[0]),
    .ctl, .lo_pos, .hi_pos, .busy,
    .out_valid, .out_result, .out_status, .out_count
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     sel;
    logic signed [DATA_W-1:0] from_lo, from_hi, comp_in;
    // Shifts act from lo_pos up to hi_pos; walks rotate the cells below hi_pos.
    always_comb begin
      unique case (ctl.op)
        CC_SHIFT_UP:   sel = (CNT_W'(g) >= CNT_W'(lo_pos)) && (CNT_W'(g) <= hi_pos);
        CC_SHIFT_DOWN: sel = (CNT_W'(g) >= CNT_W'(lo_pos)) && (CNT_W'(g) < hi_pos);
        CC_ROTATE:     sel = CNT_W'(g) < hi_pos;
        CC_COMPACT:    sel = CNT_W'(g) < hi_pos;
        default:       sel = 1'b0;
      endcase
    end
    assign from_lo = (g == 0) ? data[0] : data[(g == 0) ? 0 : g - 1];
    assign from_hi = (CNT_W'(g) + CNT_W'(1) == hi_pos) ? data[0] :
                     data[(g == DEPTH - 1) ? g : g + 1];
    assign comp_in = from_hi;
    iss_cell u_cell (
      .clk, .ctl, .sel,
      .ins_here(CNT_W'(g) == CNT_W'(lo_pos)),
      .from_lo, .from_hi, .comp_in, .data(data[g])
    );
  end

endmodule : indexed_sequence_store
`default_nettype wire

// File: sim/indexed_sequence_store_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store testbench
// Drives directed operations, a fill to capacity and random bursts into the
// store, predicts each result with a behavioural list model or a fixed one and
// compares every strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_sequence_store_test;
  import iss_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam int NUM_RANDOM = 1600;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [DATA_W-1:0]  value;
    logic signed [INDEX_W-1:0] index;
  } op_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] result;
    logic [STATUS_W-1:0]      status;
    logic [6:0]               count;
  } op_result_t;

  typedef struct {
    op_item_t   item;
    logic       known;
    op_result_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic signed [INDEX_W-1:0] in_index = '0;
  logic out_valid;
  logic signed [DATA_W-1:0] out_result;
  logic [STATUS_W-1:0] out_status;
  logic [6:0] out_count;

  logic signed [DATA_W-1:0] list_words[LIST_DEPTH];
  int list_len;
  op_result_t pending_results[$];
  op_result_t fixed_results[$];
  logic fixed_known[$];
  int error_count = 0;
  longint cycle_count = 0;

  indexed_sequence_store uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_value(in_value), .in_index(in_index),
    .out_valid(out_valid), .out_result(out_result),
    .out_status(out_status), .out_count(out_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
  endfunction

  function automatic op_result_t apply_list_op(op_item_t it);
    op_result_t r;
    int idx;
    int pos;
    int w;
    logic found;
    logic signed [DATA_W-1:0] t;
    r.result = '0;
    r.status = ST_OK;
    idx = int'(it.index);
    case (it.func)
      FN_APPEND, FN_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = list_len;
          if (it.func == FN_INSERT) begin
            if (idx < 0) idx += list_len + 1;
            if (idx < 0) idx = 0;
            if (idx > list_len) idx = list_len;
            pos = idx;
          end
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
          list_words[pos] = it.value;
          list_len++;
        end
      end
      FN_REMOVE, FN_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (idx < 0) idx += list_len;
          if (idx < 0) idx = 0;
          if (idx > list_len - 1) idx = list_len - 1;
          if (it.func == FN_POP) r.result = list_words[idx];
          drop_at(idx);
        end
      end
      FN_RM_FIRST, FN_RM_LAST: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          found = 1'b0;
          pos = 0;
          for (int i = 0; i < list_len && !found; i++) begin
            w = (it.func == FN_RM_FIRST) ? i : list_len - 1 - i;
            if (list_words[w] == it.value) begin
              found = 1'b1;
              pos = w;
            end
          end
          if (found) drop_at(pos);
          else r.status = ST_NOTFOUND;
        end
      end
      FN_RM_ALL: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          w = 0;
          for (int i = 0; i < list_len; i++) begin
            if (list_words[i] != it.value) begin
              list_words[w] = list_words[i];
              w++;
            end
          end
          if (w == list_len) r.status = ST_NOTFOUND;
          list_len = w;
        end
      end
      FN_REVERSE: begin
        for (int i = 0; i < list_len / 2; i++) begin
          t = list_words[i];
          list_words[i] = list_words[list_len - 1 - i];
          list_words[list_len - 1 - i] = t;
        end
      end
      FN_MIN, FN_MAX: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
          r.result = (it.func == FN_MIN) ? INT_MAX : INT_MIN;
        end else begin
          r.result = list_words[0];
          for (int i = 1; i < list_len; i++) begin
            if (it.func == FN_MIN ? (list_words[i] < r.result)
                                  : (list_words[i] > r.result))
              r.result = list_words[i];
          end
        end
      end
      FN_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = list_len[6:0];
    return r;
  endfunction

  // Drives one item, waits for the edge that takes it and books its prediction.
  // Busy only changes at a rising edge, so its value at the falling edge is the
  // one that the next rising edge sees.
  task automatic send_op(op_item_t it, logic known, op_result_t want);
    logic busy_seen;
    in_func <= it.func;
    in_value <= it.value;
    in_index <= it.index;
    start <= 1'b1;
    busy_seen = 1'b1;
    while (busy_seen) begin
      @(negedge clk);
      busy_seen = busy;
      @(posedge clk);
    end
    pending_results.push_back(apply_list_op(it));
    fixed_known.push_back(known);
    fixed_results.push_back(want);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return INT_MAX;
      1: return INT_MIN;
      2: return $urandom;
      default: return $signed($urandom_range(0, 7)) - 3;
    endcase
  endfunction

  function automatic op_item_t random_op();
    op_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) it.func = FN_APPEND;
    else if (sel < 45) it.func = FN_INSERT;
    else if (sel < 95) it.func = 4'($urandom_range(2, 10));
    else it.func = 4'($urandom_range(0, 15));
    if (it.func == FN_CLEAR && $urandom_range(0, 3) != 0) it.func = FN_APPEND;
    it.value = pick_value();
    it.index = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                          : 8'($signed($urandom_range(0, 80)) - 40);
    return it;
  endfunction

  always @(posedge clk) begin
    op_result_t w;
    op_result_t f;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_result, '0);
      end else begin
        w = pending_results.pop_front();
        f = fixed_results.pop_front();
        if (fixed_known.pop_front()) w = f;
        if (out_result !== w.result) report_mismatch("result", out_result, w.result);
        if (out_status !== w.status)
          report_mismatch("status", 32'(out_status), 32'(w.status));
        if (out_count !== w.count)
          report_mismatch("count", 32'(out_count), 32'(w.count));
      end
    end
  end

  table_row_t directed[$];

  function automatic void add_row(func_t f, logic signed [31:0] v, logic signed [7:0] ix,
                                  logic known = 0, logic signed [31:0] r = 0,
                                  status_t s = ST_OK, logic [6:0] c = 0);
    table_row_t row;
    row.item.func = f;
    row.item.value = v;
    row.item.index = ix;
    row.known = known;
    row.want.result = r;
    row.want.status = s;
    row.want.count = c;
    directed.push_back(row);
  endfunction

  initial begin
    op_item_t it;
    op_result_t none;
    int gap;
    none = '{default: '0};
    list_len = 0;
    add_row(FN_POP, 0, 0, 1, 0, ST_EMPTY, 0);
    add_row(FN_REMOVE, 0, -128, 1, 0, ST_EMPTY, 0);
    add_row(FN_RM_FIRST, 5, 0, 1, 0, ST_EMPTY, 0);
    add_row(FN_RM_LAST, 5, 0, 1, 0, ST_EMPTY, 0);
    add_row(FN_RM_ALL, 5, 0, 1, 0, ST_EMPTY, 0);
    add_row(FN_MIN, 0, 0, 1, INT_MAX, ST_EMPTY, 0);
    add_row(FN_MAX, 0, 0, 1, INT_MIN, ST_EMPTY, 0);
    add_row(FN_REVERSE, 0, 0, 1, 0, ST_OK, 0);
    add_row(FN_APPEND, INT_MAX, 0, 1, 0, ST_OK, 1);
    add_row(FN_APPEND, INT_MIN, 0, 1, 0, ST_OK, 2);
    add_row(FN_INSERT, 7, -128);
    add_row(FN_INSERT, -1, 127);
    add_row(FN_INSERT, 7, -1);
    add_row(FN_MIN, 0, 0);
    add_row(FN_MAX, 0, 0);
    add_row(FN_RM_FIRST, 99, 0);
    add_row(FN_RM_LAST, 7, 0);
    add_row(FN_REVERSE, 0, 0);
    add_row(FN_POP, 0, 127);
    add_row(FN_POP, 0, -128);
    add_row(FN_REMOVE, 0, -1);
    add_row(FN_RM_ALL, 7, 0);
    add_row(func_t'(4'd15), -1, -1);
    add_row(FN_CLEAR, 0, 0, 1, 0, ST_OK, 0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_op(directed[i].item, directed[i].known, directed[i].want);
    // Fill to capacity so that the full store and rejection are reached.
    for (int i = 0; i < LIST_DEPTH + 2; i++) begin
      it.func = (i % 2) ? FN_INSERT : FN_APPEND;
      it.value = $urandom;
      it.index = 8'($urandom);
      send_op(it, 0, none);
    end
    for (int n = 0; n < NUM_RANDOM; ) begin
      for (int b = $urandom_range(1, 20); b > 0 && n < NUM_RANDOM; b--, n++) begin
        send_op(random_op(), 0, none);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: indexed_sequence_store.f
src/iss_pkg.sv
src/iss_cell.sv
src/iss_ctrl.sv
src/indexed_sequence_store.sv
sim/indexed_sequence_store_test.sv
